@@ hw/rtl/png_chunk_deframer_defines.svh @@
// Assertion helpers for the chunk deframer.
`ifndef PNG_CHUNK_DEFRAMER_DEFINES_SVH
`define PNG_CHUNK_DEFRAMER_DEFINES_SVH

// same-cycle implication
`define PCD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pcd_pkg.sv @@
package pcd_pkg;

    localparam int unsigned QueueDepthDef = 4;
    localparam int unsigned MTdataW       = 96;

    localparam logic [3:0] ErrNone      = 4'd0;
    localparam logic [3:0] ErrEarlyEnd  = 4'd1;
    localparam logic [3:0] ErrLenHigh   = 4'd2;
    localparam logic [3:0] ErrIhdrLen   = 4'd3;
    localparam logic [3:0] ErrNotIhdr   = 4'd4;
    localparam logic [3:0] ErrBitDepth  = 4'd5;
    localparam logic [3:0] ErrColorType = 4'd6;
    localparam logic [3:0] ErrCompress  = 4'd7;
    localparam logic [3:0] ErrFilter    = 4'd8;
    localparam logic [3:0] ErrInterlace = 4'd9;
    localparam logic [3:0] ErrIdatSplit = 4'd10;
    localparam logic [3:0] ErrPlteMiss  = 4'd11;
    localparam logic [3:0] ErrPlteOrder = 4'd12;
    localparam logic [3:0] ErrCritical  = 4'd13;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        header_valid;
        logic [30:0] image_width;
        logic [30:0] image_height;
        logic [7:0]  bit_depth;
        logic [7:0]  color_type;
        logic        interlaced;
        logic        finished;
        logic [3:0]  error_code;
    } t_result;

    typedef struct packed {
        logic       done;
        logic [3:0] err;
    } t_front_status;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ hw/rtl/pcd_front.sv @@
module pcd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    output pcd_pkg::t_result       o_result,
    output pcd_pkg::t_front_status o_status
);
    import pcd_pkg::*;

    localparam logic [3:0] PhIhdrLen  = 4'd0;
    localparam logic [3:0] PhIhdrName = 4'd1;
    localparam logic [3:0] PhWidth    = 4'd2;
    localparam logic [3:0] PhHeight   = 4'd3;
    localparam logic [3:0] PhFormat   = 4'd4;
    localparam logic [3:0] PhCrc      = 4'd5;
    localparam logic [3:0] PhLen      = 4'd6;
    localparam logic [3:0] PhName     = 4'd7;
    localparam logic [3:0] PhData     = 4'd8;
    localparam logic [3:0] PhDone     = 4'd9;

    localparam logic [1:0] KindSkip = 2'd0;
    localparam logic [1:0] KindIdat = 2'd1;
    localparam logic [1:0] KindIend = 2'd2;
    localparam logic [1:0] KindIhdr = 2'd3;

    localparam logic [31:0] NameIhdr = 32'h4948_4452;
    localparam logic [31:0] NameIdat = 32'h4944_4154;
    localparam logic [31:0] NamePlte = 32'h504C_5445;
    localparam logic [31:0] NameIend = 32'h4945_4E44;
    localparam logic [31:0] IhdrLen  = 32'd13;

    // seen bits: 0 IDAT seen, 1 PLTE seen, 2 previous chunk was IDAT
    localparam int unsigned SeenIdat = 0;
    localparam int unsigned SeenPlte = 1;
    localparam int unsigned SeenPrev = 2;

    function automatic logic [3:0] fmt_check(input logic [7:0] depth, input logic [7:0] ctype,
                                             input logic [7:0] comp, input logic [7:0] filt,
                                             input logic [7:0] intl);
        logic ok;
        logic bad_type;
        begin
            ok = 1'b0;
            bad_type = 1'b0;
            case (ctype)
                8'd0: ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8, 8'd16};
                8'd3: ok = depth inside {8'd1, 8'd2, 8'd4, 8'd8};
                8'd2, 8'd4, 8'd6: ok = depth inside {8'd8, 8'd16};
                default: bad_type = 1'b1;
            endcase
            if (bad_type) begin
                fmt_check = ErrColorType;
            end else if (!ok) begin
                fmt_check = ErrBitDepth;
            end else if (comp != 8'd0) begin
                fmt_check = ErrCompress;
            end else if (filt != 8'd0) begin
                fmt_check = ErrFilter;
            end else if (intl > 8'd1) begin
                fmt_check = ErrInterlace;
            end else begin
                fmt_check = ErrNone;
            end
        end
    endfunction

    logic [3:0]  r_phase, n_phase;
    logic [30:0] r_cnt, n_cnt;
    logic [30:0] r_len, n_len;
    logic [31:0] r_word, n_word;
    logic [1:0]  r_kind, n_kind;
    logic [2:0]  r_seen, n_seen;
    logic        r_hv, n_hv;
    logic [3:0]  r_err, n_err;
    logic [30:0] r_width, n_width;
    logic [30:0] r_height, n_height;
    logic [7:0]  r_depth, n_depth;
    logic [7:0]  r_ctype, n_ctype;
    logic [7:0]  r_comp, n_comp;
    logic [7:0]  r_filt, n_filt;
    logic        r_intl, n_intl;

    logic [30:0] cnt_inc;
    logic        word_done;
    logic        go;
    logic        pv;
    logic [3:0]  err;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_word   = r_word;
        n_kind   = r_kind;
        n_seen   = r_seen;
        n_hv     = r_hv;
        n_err    = r_err;
        n_width  = r_width;
        n_height = r_height;
        n_depth  = r_depth;
        n_ctype  = r_ctype;
        n_comp   = r_comp;
        n_filt   = r_filt;
        n_intl   = r_intl;
        cnt_inc  = r_cnt + 31'd1;
        word_done = 1'b0;
        go       = 1'b0;
        pv       = 1'b0;
        err      = ErrNone;
        if (i_fire && r_err == ErrNone && r_phase != PhDone) begin
            n_word = {r_word[23:0], i_data};
            n_cnt  = cnt_inc;
            word_done = !(r_phase inside {PhData, PhFormat, PhCrc}) && cnt_inc == 31'd4;
            if (word_done) begin
                n_cnt = '0;
            end
            case (r_phase)
                PhIhdrLen, PhLen: begin
                    if (word_done) begin
                        if (n_word[31]) begin
                            err = ErrLenHigh;
                        end else if (r_phase == PhIhdrLen && n_word != IhdrLen) begin
                            err = ErrIhdrLen;
                        end else begin
                            n_len   = n_word[30:0];
                            n_phase = (r_phase == PhIhdrLen) ? PhIhdrName : PhName;
                        end
                    end
                end
                PhIhdrName: begin
                    if (word_done) begin
                        if (n_word != NameIhdr) begin
                            err = ErrNotIhdr;
                        end else begin
                            n_phase = PhWidth;
                        end
                    end
                end
                PhWidth, PhHeight: begin
                    if (word_done) begin
                        if (n_word[31]) begin
                            err = ErrLenHigh;
                        end else if (r_phase == PhWidth) begin
                            n_width = n_word[30:0];
                            n_phase = PhHeight;
                        end else begin
                            n_height = n_word[30:0];
                            n_phase  = PhFormat;
                        end
                    end
                end
                PhFormat: begin
                    case (r_cnt[2:0])
                        3'd0: n_depth = i_data;
                        3'd1: n_ctype = i_data;
                        3'd2: n_comp  = i_data;
                        3'd3: n_filt  = i_data;
                        default: begin
                            n_cnt  = '0;
                            n_intl = i_data[0];
                            err    = fmt_check(r_depth, r_ctype, r_comp, r_filt, i_data);
                            if (err == ErrNone) begin
                                n_hv    = 1'b1;
                                n_kind  = KindIhdr;
                                n_phase = PhCrc;
                            end
                        end
                    endcase
                end
                PhCrc: begin
                    if (cnt_inc == 31'd4) begin
                        n_cnt = '0;
                        if (r_kind == KindIend) begin
                            if (!r_seen[SeenIdat]) begin
                                err = ErrCritical;
                            end else begin
                                n_phase = PhDone;
                            end
                        end else begin
                            n_phase = PhLen;
                        end
                    end
                end
                PhName: begin
                    if (word_done) begin
                        if (n_word[29]) begin
                            n_seen[SeenPrev] = 1'b0;
                            n_kind = KindSkip;
                            go     = 1'b1;
                        end else if (n_word == NameIdat) begin
                            if (r_seen[SeenIdat] && !r_seen[SeenPrev]) begin
                                err = ErrIdatSplit;
                            end else if (r_ctype == 8'd3 && !r_seen[SeenPlte]) begin
                                err = ErrPlteMiss;
                            end else begin
                                n_seen[SeenIdat] = 1'b1;
                                n_seen[SeenPrev] = 1'b1;
                                n_kind = KindIdat;
                                go     = 1'b1;
                            end
                        end else begin
                            n_seen[SeenPrev] = 1'b0;
                            if (n_word == NamePlte) begin
                                if (r_seen[SeenIdat]) begin
                                    err = ErrPlteOrder;
                                end else begin
                                    n_seen[SeenPlte] = 1'b1;
                                    n_kind = KindSkip;
                                    go     = 1'b1;
                                end
                            end else if (n_word == NameIend) begin
                                n_kind  = KindIend;
                                n_phase = PhCrc;
                            end else begin
                                err = ErrCritical;
                            end
                        end
                        if (go) begin
                            n_phase = (r_len == '0) ? PhCrc : PhData;
                        end
                    end
                end
                PhData: begin
                    pv = (r_kind == KindIdat);
                    if (cnt_inc >= r_len) begin
                        n_cnt   = '0;
                        n_phase = PhCrc;
                    end
                end
                default: n_phase = PhDone;
            endcase
            if (err == ErrNone && i_last && n_phase != PhDone) begin
                err = ErrEarlyEnd;
            end
            n_err = err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PhIhdrLen;
            r_cnt   <= '0;
            r_kind  <= KindSkip;
            r_seen  <= '0;
            r_hv    <= 1'b0;
            r_err   <= ErrNone;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
            r_seen  <= n_seen;
            r_hv    <= n_hv;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_word   <= n_word;
        r_width  <= n_width;
        r_height <= n_height;
        r_depth  <= n_depth;
        r_ctype  <= n_ctype;
        r_comp   <= n_comp;
        r_filt   <= n_filt;
        r_intl   <= n_intl;
    end

    always_comb begin
        o_result.payload_valid = pv;
        o_result.payload_byte  = pv ? i_data : 8'd0;
        o_result.header_valid  = n_hv;
        o_result.image_width   = n_hv ? n_width : '0;
        o_result.image_height  = n_hv ? n_height : '0;
        o_result.bit_depth     = n_hv ? n_depth : 8'd0;
        o_result.color_type    = n_hv ? n_ctype : 8'd0;
        o_result.interlaced    = n_hv & n_intl;
        o_result.finished      = (n_phase == PhDone) && (n_err == ErrNone);
        o_result.error_code    = n_err;
    end

    assign o_status.done = (r_phase == PhDone);
    assign o_status.err  = r_err;

endmodule

@@ hw/rtl/pcd_queue.sv @@
module pcd_queue #(
    parameter int unsigned Depth = pcd_pkg::QueueDepthDef
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  pcd_pkg::t_result        i_data,
    input  logic                    i_pop,
    output pcd_pkg::t_result        o_head,
    output pcd_pkg::t_queue_status  o_status
);
    import pcd_pkg::*;

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    t_result         r_mem [Depth];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.full  = (r_count == CntW'(Depth));
    assign o_status.empty = (r_count == '0);

endmodule

@@ hw/rtl/pcd_back.sv @@
module pcd_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcd_pkg::t_result               i_head,
    input  pcd_pkg::t_queue_status         i_qstat,
    output logic                           o_pop,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pcd_pkg::MTdataW-1:0]    o_m_tdata,
    output logic                           o_m_tuser
);
    import pcd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_pop = !i_qstat.empty && (!r_valid || i_m_tready);

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_m_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tuser  = r_res.payload_valid;
    assign o_m_tdata  = {3'b000, r_res.error_code, r_res.finished, r_res.interlaced,
                         r_res.color_type, r_res.bit_depth, r_res.image_height,
                         r_res.image_width, r_res.header_valid, r_res.payload_byte};

endmodule

@@ hw/rtl/png_chunk_deframer.sv @@
// PNG chunk deframer.
// Slave stream: one byte of the chunk stream (after the signature) per beat in
// s_tdata[7:0]; s_tlast marks the last byte available.
// Master stream: one result beat per input beat, in order. m_tuser is the
// payload flag (IDAT data byte). m_tdata from bit 0: payload byte, header valid,
// width (31), height (31), bit depth, color type, interlaced, finished,
// error code (4), zero pad to 96 bits.
// Throughput: one byte per cycle while s_tready is high. A byte's result is
// formed combinationally and passes through the queue and output register.
// The parser updates its state once per accepted byte; a result queue of
// QUEUE_DEPTH entries plus the output register decouple it from the sink.
// When the sink holds m_tready low, results collect in the queue and s_tready
// drops once it is full; nothing is dropped or repeated.
// Reset (synchronous, active low) returns the parser to expecting the IHDR
// length, clears flags and errors, and empties the queue and output stage.
// Errors are sticky: later bytes are still taken and answered with held fields.
`include "png_chunk_deframer_defines.svh"

module png_chunk_deframer #(
    parameter int unsigned QUEUE_DEPTH = pcd_pkg::QueueDepthDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] data_byte
    input  logic                        i_s_tlast,   // last_byte
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // [7:0] payload_byte, [8] header_valid, [39:9] image_width,
    // [70:40] image_height, [78:71] bit_depth, [86:79] color_type,
    // [87] interlaced, [88] finished, [92:89] error_code, [95:93] zero
    output logic [pcd_pkg::MTdataW-1:0] o_m_tdata,
    output logic                        o_m_tuser    // payload_valid
);
    import pcd_pkg::*;

    logic          fire;
    logic          pop;
    t_result       front_res;
    t_result       q_head;
    t_front_status front_st;
    t_queue_status q_st;

    assign o_s_tready = !q_st.full;
    assign fire       = i_s_tvalid && o_s_tready;

    pcd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_data   (i_s_tdata),
        .i_last   (i_s_tlast),
        .o_result (front_res),
        .o_status (front_st)
    );

    pcd_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_data   (front_res),
        .i_pop    (pop),
        .o_head   (q_head),
        .o_status (q_st)
    );

    pcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_qstat    (q_st),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    `PCD_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, front_st.err != ErrNone, $stable(front_st.err), "error code changed after being set")
    `PCD_ASSERT_IMPLY(a_done_clean, i_clk, i_rst_n, front_st.done, front_st.err == ErrNone, "finished with an error")
    `PCD_ASSERT_IMPLY(a_queue_sane, i_clk, i_rst_n, q_st.full, !q_st.empty, "queue full and empty at once")
    `PCD_ASSERT_IMPLY(a_no_pop_stall, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !pop, "output overwritten while stalled")

endmodule

@@ bench/tb_png_chunk_deframer.sv @@
`timescale 1ns / 100ps

module tb_png_chunk_deframer;
    import pcd_pkg::*;

    localparam logic [31:0] NAME_IHDR = 32'h4948_4452;
    localparam logic [31:0] NAME_IDAT = 32'h4944_4154;
    localparam logic [31:0] NAME_PLTE = 32'h504C_5445;
    localparam logic [31:0] NAME_IEND = 32'h4945_4E44;
    localparam logic [31:0] ANCILLARY = 32'h2000_0000;
    localparam int BODY_BYTES = 1180;
    localparam int NOISE_BYTES = 40;
    localparam int LONG_HOLD = 200;

    typedef enum logic [3:0] {
        PH_IHDR_LEN, PH_IHDR_NAME, PH_WIDTH, PH_HEIGHT, PH_FORMAT,
        PH_CRC, PH_LEN, PH_NAME, PH_DATA, PH_DONE
    } parse_phase_e;

    typedef enum logic [1:0] {KIND_SKIP, KIND_IDAT, KIND_IEND, KIND_IHDR} chunk_kind_e;

    typedef enum int {
        FAULT_NONE, FAULT_EARLY_END, FAULT_LEN_HIGH, FAULT_IHDR_LEN, FAULT_NOT_IHDR,
        FAULT_WIDTH_HIGH, FAULT_BAD_DEPTH, FAULT_BAD_CTYPE, FAULT_COMP, FAULT_FILTER,
        FAULT_INTERLACE, FAULT_IDAT_SPLIT, FAULT_PLTE_MISS, FAULT_PLTE_ORDER,
        FAULT_CRITICAL, FAULT_NO_IDAT
    } stream_fault_e;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata = 8'h00;  // [7:0] data_byte
    logic                i_s_tlast = 1'b0;   // last_byte
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [MTdataW-1:0]  o_m_tdata;          // payload, header fields, status
    logic                o_m_tuser;          // payload_valid

    png_chunk_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    stream_byte_t stream_bytes[$];
    t_result      predicted_beats[$];
    int           mismatches = 0;
    int           bytes_accepted = 0;
    logic         byte_taken = 1'b0;

    // parser state mirror
    parse_phase_e phase = PH_IHDR_LEN;
    logic [31:0]  phase_count = '0;
    logic [31:0]  chunk_len = '0;
    logic [31:0]  shift_word = '0;
    chunk_kind_e  kind = KIND_SKIP;
    logic         seen_idat = 1'b0;
    logic         seen_plte = 1'b0;
    logic         prev_idat = 1'b0;
    logic [31:0]  hdr_width = '0;
    logic [31:0]  hdr_height = '0;
    logic [7:0]   fmt_bytes [0:4] = '{default: 8'h00};  // depth, ctype, comp, filter, interlace
    logic         hdr_ok = 1'b0;
    logic [3:0]   sticky_err = ErrNone;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic parse_png_byte(input logic [7:0] b, input logic last, output t_result r);
        logic [31:0] n;
        logic        word_done;
        logic        pv;
        logic        depth_ok;
        logic        ctype_bad;
        logic [7:0]  d;
        logic [3:0]  err;
        pv = 1'b0;
        err = ErrNone;
        if (sticky_err == ErrNone && phase != PH_DONE) begin
            n = phase_count + 1;
            shift_word = {shift_word[23:0], b};
            phase_count = n;
            word_done = 1'b0;
            if (phase != PH_DATA && phase != PH_FORMAT && phase != PH_CRC && n == 4) begin
                word_done = 1'b1;
                phase_count = '0;
            end
            case (phase)
                PH_IHDR_LEN, PH_LEN: if (word_done) begin
                    if (shift_word[31]) err = ErrLenHigh;
                    else if (phase == PH_IHDR_LEN && shift_word != 32'd13) err = ErrIhdrLen;
                    else begin
                        chunk_len = shift_word;
                        phase = (phase == PH_IHDR_LEN) ? PH_IHDR_NAME : PH_NAME;
                    end
                end
                PH_IHDR_NAME: if (word_done) begin
                    if (shift_word != NAME_IHDR) err = ErrNotIhdr;
                    else phase = PH_WIDTH;
                end
                PH_WIDTH, PH_HEIGHT: if (word_done) begin
                    if (shift_word[31]) err = ErrLenHigh;
                    else if (phase == PH_WIDTH) begin
                        hdr_width = shift_word;
                        phase = PH_HEIGHT;
                    end else begin
                        hdr_height = shift_word;
                        phase = PH_FORMAT;
                    end
                end
                PH_FORMAT: begin
                    fmt_bytes[3'(n - 1)] = b;
                    if (n == 5) begin
                        phase_count = '0;
                        d = fmt_bytes[0];
                        ctype_bad = 1'b0;
                        case (fmt_bytes[1])
                            8'd0: depth_ok = d == 1 || d == 2 || d == 4 || d == 8 || d == 16;
                            8'd3: depth_ok = d == 1 || d == 2 || d == 4 || d == 8;
                            8'd2, 8'd4, 8'd6: depth_ok = d == 8 || d == 16;
                            default: begin
                                depth_ok = 1'b0;
                                ctype_bad = 1'b1;
                            end
                        endcase
                        if (ctype_bad) err = ErrColorType;
                        else if (!depth_ok) err = ErrBitDepth;
                        else if (fmt_bytes[2] != 0) err = ErrCompress;
                        else if (fmt_bytes[3] != 0) err = ErrFilter;
                        else if (fmt_bytes[4] > 1) err = ErrInterlace;
                        else begin
                            hdr_ok = 1'b1;
                            kind = KIND_IHDR;
                            phase = PH_CRC;
                        end
                    end
                end
                PH_CRC: if (n == 4) begin
                    phase_count = '0;
                    if (kind == KIND_IEND) begin
                        if (!seen_idat) err = ErrCritical;
                        else phase = PH_DONE;
                    end else begin
                        phase = PH_LEN;
                    end
                end
                PH_NAME: if (word_done) begin
                    if (shift_word[29]) begin
                        prev_idat = 1'b0;
                        kind = KIND_SKIP;
                    end else if (shift_word == NAME_IDAT) begin
                        if (seen_idat && !prev_idat) err = ErrIdatSplit;
                        else if (fmt_bytes[1] == 8'd3 && !seen_plte) err = ErrPlteMiss;
                        else begin
                            seen_idat = 1'b1;
                            prev_idat = 1'b1;
                            kind = KIND_IDAT;
                        end
                    end else begin
                        prev_idat = 1'b0;
                        if (shift_word == NAME_PLTE) begin
                            if (seen_idat) err = ErrPlteOrder;
                            else begin
                                seen_plte = 1'b1;
                                kind = KIND_SKIP;
                            end
                        end else if (shift_word == NAME_IEND) begin
                            kind = KIND_IEND;
                        end else begin
                            err = ErrCritical;
                        end
                    end
                    // IEND goes to its CRC whatever its length
                    if (err == ErrNone)
                        phase = (chunk_len == 0 || kind == KIND_IEND) ? PH_CRC : PH_DATA;
                end
                PH_DATA: begin
                    if (kind == KIND_IDAT) pv = 1'b1;
                    if (n >= chunk_len) begin
                        phase_count = '0;
                        phase = PH_CRC;
                    end
                end
                default: phase = PH_DONE;
            endcase
            if (err == ErrNone && last && phase != PH_DONE) err = ErrEarlyEnd;
            sticky_err = err;
        end
        r.payload_valid = pv;
        r.payload_byte  = pv ? b : 8'h00;
        r.header_valid  = hdr_ok;
        r.image_width   = hdr_ok ? hdr_width[30:0] : '0;
        r.image_height  = hdr_ok ? hdr_height[30:0] : '0;
        r.bit_depth     = hdr_ok ? fmt_bytes[0] : 8'h00;
        r.color_type    = hdr_ok ? fmt_bytes[1] : 8'h00;
        r.interlaced    = hdr_ok & fmt_bytes[4][0];
        r.finished      = phase == PH_DONE && sticky_err == ErrNone;
        r.error_code    = sticky_err;
    endtask

    task automatic put_byte(input logic [7:0] b, input logic last);
        stream_byte_t sb;
        sb.data = b;
        sb.last = last;
        stream_bytes.push_back(sb);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8], 1'b0);
    endtask

    task automatic put_chunk(input logic [31:0] name, input int unsigned len);
        put_word(len);
        put_word(name);
        repeat (len) put_byte(8'($urandom), 1'b0);
        put_word($urandom);
    endtask

    task automatic mark_last();
        stream_byte_t sb;
        sb = stream_bytes.pop_back();
        sb.last = 1'b1;
        stream_bytes.push_back(sb);
    endtask

    function automatic logic [31:0] ancillary_name();
        return $urandom | ANCILLARY;
    endfunction

    task automatic build_stream();
        stream_fault_e fault;
        logic [31:0]   width;
        logic [31:0]   height;
        logic [31:0]   name;
        logic [7:0]    depth, ctype, comp, filt, intl;
        if ($urandom_range(0, 99) < 45) fault = FAULT_NONE;
        else fault = stream_fault_e'($urandom_range(int'(FAULT_EARLY_END), int'(FAULT_NO_IDAT)));

        // IHDR
        if (fault == FAULT_IHDR_LEN)
            put_word($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(14, 32'h7FFF_FFFF));
        else
            put_word(32'd13);
        put_word((fault == FAULT_NOT_IHDR) ? NAME_IHDR ^ (32'd1 << $urandom_range(0, 31)) : NAME_IHDR);
        case ($urandom_range(0, 2))
            0: width = 32'd0;
            1: width = 32'h7FFF_FFFF;
            default: width = $urandom & 32'h7FFF_FFFF;
        endcase
        case ($urandom_range(0, 2))
            0: height = 32'h7FFF_FFFF;
            1: height = 32'd0;
            default: height = $urandom & 32'h7FFF_FFFF;
        endcase
        if (fault == FAULT_WIDTH_HIGH) begin
            if ($urandom_range(0, 1)) width[31] = 1'b1;
            else height[31] = 1'b1;
        end
        put_word(width);
        put_word(height);

        case ($urandom_range(0, 4))
            0: ctype = 8'd0;
            1: ctype = 8'd2;
            2: ctype = 8'd3;
            3: ctype = 8'd4;
            default: ctype = 8'd6;
        endcase
        if (fault == FAULT_PLTE_MISS) ctype = 8'd3;
        if (ctype == 8'd0) depth = 8'd1 << $urandom_range(0, 4);
        else if (ctype == 8'd3) depth = 8'd1 << $urandom_range(0, 3);
        else depth = 8'd8 << $urandom_range(0, 1);
        comp = 8'd0;
        filt = 8'd0;
        intl = 8'($urandom_range(0, 1));
        case (fault)
            FAULT_BAD_CTYPE: begin
                do ctype = 8'($urandom);
                while (ctype == 0 || ctype == 2 || ctype == 3 || ctype == 4 || ctype == 6);
                depth = 8'($urandom);
                comp = 8'($urandom);
                filt = 8'($urandom);
                intl = 8'($urandom);
            end
            FAULT_BAD_DEPTH: begin
                case ($urandom_range(0, 2))
                    0: depth = 8'd0;
                    1: depth = 8'($urandom_range(17, 255));
                    default: depth = (ctype == 3) ? 8'd16 : (ctype == 0) ? 8'd3 : 8'd4;
                endcase
                comp = 8'($urandom);
                filt = 8'($urandom);
            end
            FAULT_COMP: begin
                comp = 8'($urandom_range(1, 255));
                filt = 8'($urandom);
                intl = 8'($urandom);
            end
            FAULT_FILTER: begin
                filt = 8'($urandom_range(1, 255));
                intl = 8'($urandom);
            end
            FAULT_INTERLACE: intl = 8'($urandom_range(2, 255));
            default: ;
        endcase
        put_byte(depth, 1'b0);
        put_byte(ctype, 1'b0);
        put_byte(comp, 1'b0);
        put_byte(filt, 1'b0);
        put_byte(intl, 1'b0);
        put_word($urandom);

        // chunks before image data
        put_chunk(ancillary_name(), 0);
        repeat ($urandom_range(0, 3)) put_chunk(ancillary_name(), $urandom_range(1, 16));
        if (fault != FAULT_PLTE_MISS && (ctype == 8'd3 || $urandom_range(0, 1)))
            repeat ($urandom_range(1, 2)) put_chunk(NAME_PLTE, 3 * $urandom_range(1, 8));

        // image data run
        while (stream_bytes.size() < BODY_BYTES) begin
            if (fault == FAULT_NO_IDAT)
                put_chunk(ancillary_name(), $urandom_range(0, 40));
            else
                put_chunk(NAME_IDAT, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40));
        end

        case (fault)
            FAULT_EARLY_END: mark_last();
            FAULT_LEN_HIGH: put_word({1'b1, 31'($urandom)});
            FAULT_IDAT_SPLIT: begin
                put_chunk(ancillary_name(), $urandom_range(0, 8));
                put_chunk(NAME_IDAT, $urandom_range(0, 8));
            end
            FAULT_PLTE_ORDER: put_chunk(NAME_PLTE, 3);
            FAULT_CRITICAL: begin
                do name = $urandom & ~ANCILLARY;
                while (name == NAME_IDAT || name == NAME_PLTE || name == NAME_IEND);
                put_chunk(name, $urandom_range(0, 8));
            end
            default: begin
                if ($urandom_range(0, 1)) put_chunk(ancillary_name(), $urandom_range(0, 16));
                // IEND, sometimes with a nonzero length
                put_word($urandom_range(0, 1) ? 32'd0 : $urandom_range(1, 20));
                put_word(NAME_IEND);
                put_word($urandom);
                if ($urandom_range(0, 1)) mark_last();
            end
        endcase

        // bytes past the end of the stream, answered with held fields
        repeat (NOISE_BYTES) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    task automatic check_field(input string field, input logic [63:0] want, input logic [63:0] seen);
        if (seen !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, seen);
            mismatches++;
        end
    endtask

    // sender: bursts with random gaps
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        stream_byte_t sent;
        if (i_rst_n) begin
            if (byte_taken) sent = stream_bytes.pop_front();
            if (!(i_s_tvalid && !byte_taken)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else if (stream_bytes.size() == 0) begin
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= stream_bytes[0].data;
                    i_s_tlast <= stream_bytes[0].last;
                    if (burst_left > 1) burst_left--;
                    else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // receiver: own stall pattern plus one long hold-off
    rx_mode_e    rx_mode = RX_OPEN;
    int unsigned rx_left = 20;
    int unsigned rx_tick = 0;
    int unsigned hold_left = 0;
    logic        long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (!long_hold_done && bytes_accepted >= 300) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: i_m_tready <= 1'b1;
                RX_MOSTLY: i_m_tready <= $urandom_range(0, 3) != 0;
                RX_SPARSE: i_m_tready <= $urandom_range(0, 3) == 0;
                default: i_m_tready <= (rx_tick % 5) < 3;
            endcase
            if (rx_left > 0) rx_left--;
            else begin
                rx_mode = rx_mode_e'($urandom_range(int'(RX_OPEN), int'(RX_PERIODIC)));
                rx_left = $urandom_range(10, 80);
            end
        end
    end

    // beat monitor and scoreboard
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        byte_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            parse_png_byte(i_s_tdata, i_s_tlast, want);
            predicted_beats.push_back(want);
            bytes_accepted++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.payload_valid = o_m_tuser;
            got.payload_byte  = o_m_tdata[7:0];
            got.header_valid  = o_m_tdata[8];
            got.image_width   = o_m_tdata[39:9];
            got.image_height  = o_m_tdata[70:40];
            got.bit_depth     = o_m_tdata[78:71];
            got.color_type    = o_m_tdata[86:79];
            got.interlaced    = o_m_tdata[87];
            got.finished      = o_m_tdata[88];
            got.error_code    = o_m_tdata[92:89];
            if (predicted_beats.size() == 0) begin
                $display("%0t: result beat with none expected, expected nothing, got %0h",
                         $time, o_m_tdata);
                mismatches++;
            end else begin
                want = predicted_beats.pop_front();
                check_field("payload_valid", 64'(want.payload_valid), 64'(got.payload_valid));
                check_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
                check_field("header_valid", 64'(want.header_valid), 64'(got.header_valid));
                check_field("image_width", 64'(want.image_width), 64'(got.image_width));
                check_field("image_height", 64'(want.image_height), 64'(got.image_height));
                check_field("bit_depth", 64'(want.bit_depth), 64'(got.bit_depth));
                check_field("color_type", 64'(want.color_type), 64'(got.color_type));
                check_field("interlaced", 64'(want.interlaced), 64'(got.interlaced));
                check_field("finished", 64'(want.finished), 64'(got.finished));
                check_field("error_code", 64'(want.error_code), 64'(got.error_code));
            end
        end
    end

    initial begin
        build_stream();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (stream_bytes.size() != 0 || predicted_beats.size() != 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
